@@ hw/rtl/stbc_pkg.sv @@
// ----------------------------------------------------------------------------
// stbc_pkg: shared types and constants of the servo tester button control
// Register layout, request payload, reset values and the seven-segment table.
// ----------------------------------------------------------------------------
package stbc_pkg;

	// Field widths.
	localparam int PosW  = 14;
	localparam int CntW  = 8;
	localparam int StepW = 8;
	localparam int AddrW = 5;
	localparam int DataW = 32;

	// Register reset values.
	localparam logic [CntW-1:0]  LongPressReset = 8'd20;
	localparam logic [PosW-1:0]  AngleMinReset  = 14'd0;
	localparam logic [PosW-1:0]  AngleMidReset  = 14'd90;
	localparam logic [PosW-1:0]  AngleMaxReset  = 14'd180;
	localparam logic [PosW-1:0]  PulseMinReset  = 14'd0;
	localparam logic [PosW-1:0]  PulseMidReset  = 14'd1250;
	localparam logic [PosW-1:0]  PulseMaxReset  = 14'd2500;
	localparam logic [StepW-1:0] PulseStepReset = 8'd5;

	// Decimal point bit of a segment pattern.
	localparam logic [7:0] SegDp = 8'h80;

	// Reciprocal constants for the decimal digit split (each exact over the range of its input).
	localparam logic [13:0] Recip1000 = 14'd8389;
	localparam int          Shift1000 = 23;
	localparam logic [5:0]  Recip100  = 6'd41;
	localparam int          Shift100  = 12;
	localparam logic [7:0]  Recip10   = 8'd205;
	localparam int          Shift10   = 11;

	// Register indexes on the configuration port.
	typedef enum logic [2:0] {
		REG_LONG_PRESS = 3'd0,
		REG_ANGLE_MIN  = 3'd1,
		REG_ANGLE_MID  = 3'd2,
		REG_ANGLE_MAX  = 3'd3,
		REG_PULSE_MIN  = 3'd4,
		REG_PULSE_MID  = 3'd5,
		REG_PULSE_MAX  = 3'd6,
		REG_PULSE_STEP = 3'd7
	} stbc_reg_idx_t;

	// Configuration register contents.
	typedef struct packed {
		logic [CntW-1:0]  long_press_ticks;
		logic [PosW-1:0]  angle_min;
		logic [PosW-1:0]  angle_mid;
		logic [PosW-1:0]  angle_max;
		logic [PosW-1:0]  pulse_min;
		logic [PosW-1:0]  pulse_mid;
		logic [PosW-1:0]  pulse_max;
		logic [StepW-1:0] pulse_step;
	} stbc_cfg_t;

	// Updated state handed from the front part to the display back part.
	typedef struct packed {
		logic [PosW-1:0] position;
		logic            pulse_mode;
		logic            beep;
	} stbc_item_t;

	// Active-high segments a..g in bits 0..6; digits above nine are blank.
	function automatic logic [6:0] digit_seg(input logic [3:0] d);
		logic [6:0] s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

@@ hw/rtl/stbc_if.sv @@
// ----------------------------------------------------------------------------
// stbc_if: request channels of the servo tester button control
// Button tick channel and display result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface stbc_in_if;
	logic valid;
	logic ready;
	logic left_pressed;
	logic middle_pressed;
	logic right_pressed;

	modport source (output valid, left_pressed, middle_pressed, right_pressed,
		input ready);
	modport sink (input valid, left_pressed, middle_pressed, right_pressed,
		output ready);
endinterface

interface stbc_out_if import stbc_pkg::*;;
	logic            valid;
	logic            ready;
	logic [PosW-1:0] position;
	logic            pulse_mode;
	logic            beep;
	logic [7:0]      thousands_segments;
	logic [7:0]      hundreds_segments;
	logic [7:0]      tens_segments;
	logic [7:0]      ones_segments;

	modport source (output valid, position, pulse_mode, beep, thousands_segments,
		hundreds_segments, tens_segments, ones_segments, input ready);
	modport sink (input valid, position, pulse_mode, beep, thousands_segments,
		hundreds_segments, tens_segments, ones_segments, output ready);
endinterface

@@ hw/rtl/stbc_cfg.sv @@
// ----------------------------------------------------------------------------
// stbc_cfg: configuration register file
// APB-style write and read access to the eight limit and timing registers.
// ----------------------------------------------------------------------------
module stbc_cfg import stbc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output stbc_cfg_t        cfg
);

	stbc_cfg_t     cfg_q;
	stbc_reg_idx_t reg_idx;
	logic          wr_en;

	assign reg_idx = stbc_reg_idx_t'(paddr[AddrW-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Register writes, truncated to each register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks <= LongPressReset;
			cfg_q.angle_min        <= AngleMinReset;
			cfg_q.angle_mid        <= AngleMidReset;
			cfg_q.angle_max        <= AngleMaxReset;
			cfg_q.pulse_min        <= PulseMinReset;
			cfg_q.pulse_mid        <= PulseMidReset;
			cfg_q.pulse_max        <= PulseMaxReset;
			cfg_q.pulse_step       <= PulseStepReset;
		end else if (wr_en) begin
			case (reg_idx)
				REG_LONG_PRESS: cfg_q.long_press_ticks <= pwdata[CntW-1:0];
				REG_ANGLE_MIN:  cfg_q.angle_min        <= pwdata[PosW-1:0];
				REG_ANGLE_MID:  cfg_q.angle_mid        <= pwdata[PosW-1:0];
				REG_ANGLE_MAX:  cfg_q.angle_max        <= pwdata[PosW-1:0];
				REG_PULSE_MIN:  cfg_q.pulse_min        <= pwdata[PosW-1:0];
				REG_PULSE_MID:  cfg_q.pulse_mid        <= pwdata[PosW-1:0];
				REG_PULSE_MAX:  cfg_q.pulse_max        <= pwdata[PosW-1:0];
				REG_PULSE_STEP: cfg_q.pulse_step       <= pwdata[StepW-1:0];
				default: ;
			endcase
		end
	end

	// Read data, zero extended.
	always_comb begin
		case (reg_idx)
			REG_LONG_PRESS: prdata = DataW'(cfg_q.long_press_ticks);
			REG_ANGLE_MIN:  prdata = DataW'(cfg_q.angle_min);
			REG_ANGLE_MID:  prdata = DataW'(cfg_q.angle_mid);
			REG_ANGLE_MAX:  prdata = DataW'(cfg_q.angle_max);
			REG_PULSE_MIN:  prdata = DataW'(cfg_q.pulse_min);
			REG_PULSE_MID:  prdata = DataW'(cfg_q.pulse_mid);
			REG_PULSE_MAX:  prdata = DataW'(cfg_q.pulse_max);
			REG_PULSE_STEP: prdata = DataW'(cfg_q.pulse_step);
			default:        prdata = '0;
		endcase
	end

endmodule

@@ hw/rtl/stbc_front.sv @@
// ----------------------------------------------------------------------------
// stbc_front: button tick front end
// Takes one tick per cycle while the queue has room, applies steps, long
// press and the middle-button cycle to the position and queues the new state.
// ----------------------------------------------------------------------------
module stbc_front import stbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  stbc_cfg_t  cfg,
	stbc_in_if.sink    btn,
	input  logic       q_full,
	output logic       push,
	output stbc_item_t push_item
);

	logic [PosW-1:0]  pos_q;
	logic             mode_q;
	logic [CntW-1:0]  cnt_q;
	logic             lock_q;
	logic             mid_was_q;

	logic [PosW-1:0]  lo, md, hi, md_other;
	logic [StepW-1:0] step;
	logic [PosW:0]    dn_limit, up_sum_a;
	logic [PosW-1:0]  pos_a, pos_b, pos_cyc, pos_n;
	logic [CntW:0]    cnt_inc;
	logic             long_press, release_evt, mode_n;
	logic [CntW-1:0]  cnt_n;
	logic             lock_n;
	logic             accept;

	assign btn.ready = !q_full;
	assign accept    = btn.valid && btn.ready;

	// Limits of the current mode; angle mode steps by one.
	always_comb begin
		if (mode_q) begin
			lo       = cfg.pulse_min;
			md       = cfg.pulse_mid;
			hi       = cfg.pulse_max;
			step     = cfg.pulse_step;
			md_other = cfg.angle_mid;
		end else begin
			lo       = cfg.angle_min;
			md       = cfg.angle_mid;
			hi       = cfg.angle_max;
			step     = StepW'(1);
			md_other = cfg.pulse_mid;
		end
	end

	// Down step first, then up step, each only when it stays within limits.
	assign dn_limit = {1'b0, lo} + (PosW+1)'(step);
	assign pos_a    = (btn.left_pressed && ({1'b0, pos_q} >= dn_limit)) ?
		pos_q - PosW'(step) : pos_q;
	assign up_sum_a = {1'b0, pos_a} + (PosW+1)'(step);
	assign pos_b    = (btn.right_pressed && (up_sum_a <= {1'b0, hi})) ?
		up_sum_a[PosW-1:0] : pos_a;

	// Long press detection on the unlocked middle button.
	assign cnt_inc     = {1'b0, cnt_q} + (CntW+1)'(1);
	assign long_press  = !lock_q && btn.middle_pressed &&
		(cnt_inc > {1'b0, cfg.long_press_ticks});
	assign release_evt = !btn.middle_pressed && mid_was_q;
	assign mode_n      = mode_q ^ long_press;

	// Release cycle: min to mid, mid to max, max to min, anything else to mid.
	always_comb begin
		if (pos_b == lo) begin
			pos_cyc = md;
		end else if (pos_b == md) begin
			pos_cyc = hi;
		end else if (pos_b == hi) begin
			pos_cyc = lo;
		end else begin
			pos_cyc = md;
		end
	end

	// Next position, counter and lock.
	always_comb begin
		pos_n  = pos_b;
		cnt_n  = cnt_q;
		lock_n = lock_q;
		if (long_press) begin
			pos_n  = md_other;
			lock_n = 1'b1;
		end
		if (!lock_q && btn.middle_pressed) begin
			cnt_n = cnt_inc[CntW] ? {CntW{1'b1}} : cnt_inc[CntW-1:0];
		end
		if (release_evt) begin
			cnt_n = '0;
			if (lock_q) begin
				lock_n = 1'b0;
			end else begin
				pos_n = pos_cyc;
			end
		end
	end

	// State update on each accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= AngleMidReset;
			mode_q    <= 1'b0;
			cnt_q     <= '0;
			lock_q    <= 1'b0;
			mid_was_q <= 1'b0;
		end else if (accept) begin
			pos_q     <= pos_n;
			mode_q    <= mode_n;
			cnt_q     <= cnt_n;
			lock_q    <= lock_n;
			mid_was_q <= btn.middle_pressed;
		end
	end

	assign push                = accept;
	assign push_item.position   = pos_n;
	assign push_item.pulse_mode = mode_n;
	assign push_item.beep       = long_press;

endmodule

@@ hw/rtl/stbc_queue.sv @@
// ----------------------------------------------------------------------------
// stbc_queue: short queue between front and back
// Register-based FIFO of updated states so either side can stall alone.
// ----------------------------------------------------------------------------
module stbc_queue import stbc_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  stbc_item_t push_item,
	output logic       full,
	input  logic       pop,
	output stbc_item_t head_item,
	output logic       empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	stbc_item_t      mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full      = (count_q == CntW'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_item = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

@@ hw/rtl/stbc_back.sv @@
// ----------------------------------------------------------------------------
// stbc_back: display back end
// Splits the position into decimal digits over five stages and registers
// the result request with its seven-segment patterns.
// ----------------------------------------------------------------------------
module stbc_back import stbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  stbc_item_t head_item,
	output logic       pop,
	stbc_out_if.source disp
);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;

	stbc_item_t it_s1, it_s2, it_s3, it_s4, it_s5;
	logic [4:0] thou_s1, thou_s2, thou_s3, thou_s4, thou_s5;
	logic [9:0] rem1_s2, rem1_s3;
	logic [3:0] hund_s3, hund_s4, hund_s5;
	logic [6:0] rem2_s4, rem2_s5;
	logic [3:0] tens_s5;

	logic [27:0]     prod1000;
	logic [PosW-1:0] sub1000;
	logic [15:0]     prod100;
	logic [9:0]      sub100;
	logic [14:0]     prod10;
	logic [6:0]      sub10;

	logic [PosW-1:0] position_q;
	logic            pulse_mode_q, beep_q;
	logic [7:0]      thou_seg_q, hund_seg_q, tens_seg_q, ones_seg_q;

	// The whole pipeline moves when the output register is free or taken.
	assign adv = !out_valid_q || disp.ready;
	assign pop = adv && !q_empty;

	// Reciprocal multiplies and remainder subtractions, one per stage.
	assign prod1000 = 28'(head_item.position) * 28'(Recip1000);
	assign sub1000  = it_s1.position - PosW'(thou_s1) * PosW'(1000);
	assign prod100  = 16'(rem1_s2) * 16'(Recip100);
	assign sub100   = rem1_s3 - 10'(hund_s3) * 10'd100;
	assign prod10   = 15'(rem2_s4) * 15'(Recip10);
	assign sub10    = rem2_s5 - 7'(tens_s5) * 7'd10;

	// Stage valids and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	// Digit split pipeline.
	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1   <= head_item;
			thou_s1 <= prod1000[Shift1000 +: 5];

			it_s2   <= it_s1;
			thou_s2 <= thou_s1;
			rem1_s2 <= sub1000[9:0];

			it_s3   <= it_s2;
			thou_s3 <= thou_s2;
			rem1_s3 <= rem1_s2;
			hund_s3 <= prod100[Shift100 +: 4];

			it_s4   <= it_s3;
			thou_s4 <= thou_s3;
			hund_s4 <= hund_s3;
			rem2_s4 <= sub100[6:0];

			it_s5   <= it_s4;
			thou_s5 <= thou_s4;
			hund_s5 <= hund_s4;
			rem2_s5 <= rem2_s4;
			tens_s5 <= prod10[Shift10 +: 4];

			position_q   <= it_s5.position;
			pulse_mode_q <= it_s5.pulse_mode;
			beep_q       <= it_s5.beep;
			thou_seg_q   <= {!it_s5.pulse_mode,
				(thou_s5 < 5'd10) ? digit_seg(thou_s5[3:0]) : 7'h00};
			hund_seg_q   <= {1'b0, digit_seg(hund_s5)};
			tens_seg_q   <= {1'b0, digit_seg(tens_s5)};
			ones_seg_q   <= {it_s5.pulse_mode, digit_seg(sub10[3:0])};
		end
	end

	// Result request.
	assign disp.valid              = out_valid_q;
	assign disp.position           = position_q;
	assign disp.pulse_mode         = pulse_mode_q;
	assign disp.beep               = beep_q;
	assign disp.thousands_segments = thou_seg_q;
	assign disp.hundreds_segments  = hund_seg_q;
	assign disp.tens_segments      = tens_seg_q;
	assign disp.ones_segments      = ones_seg_q;

endmodule

@@ hw/rtl/servo_tester_button_control.sv @@
// ----------------------------------------------------------------------------
// servo_tester_button_control: button handling of a servo tester
// Throughput: one tick per cycle while the queue has room.
// The position update loops through the front-end state registers; each tick
// then passes the queue, the five-stage digit split and the output register.
// The queue between them holds QUEUE_DEPTH updated states.
// Reset: asynchronous, active low; position 90 in angle mode, default limits.
// ----------------------------------------------------------------------------
module servo_tester_button_control import stbc_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	stbc_in_if.sink          btn,
	stbc_out_if.source       disp
);

	stbc_cfg_t  cfg;
	logic       push, pop, q_full, q_empty;
	stbc_item_t push_item, head_item;

	// Configuration registers.
	stbc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Tick front end.
	stbc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.btn       (btn),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// Decoupling queue.
	stbc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head_item (head_item),
		.empty     (q_empty)
	);

	// Display back end.
	stbc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head_item (head_item),
		.pop       (pop),
		.disp      (disp)
	);

endmodule

@@ sim/tb_servo_tester_button_control.sv @@
// ----------------------------------------------------------------------------
// tb_servo_tester_button_control: self-checking bench of the button control
// Button ticks go in on the input channel while the display channel is drained
// at random. A scoreboard keeps its own copy of the position, the mode and the
// long-press tracking, predicts every display request and compares it field by
// field. Limits are rewritten between phases over the APB port, extremes
// included, and the phases cycle through four mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_servo_tester_button_control;
	import stbc_pkg::*;

	localparam int StallLimit = 4000;
	localparam int MaxReports = 10;

	// Active-high segments a..g for the digits zero to nine.
	localparam logic [6:0] Glyph [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
		7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

	// One display request as seen on the result channel.
	typedef struct packed {
		logic [PosW-1:0] position;
		logic            pulse_mode;
		logic            beep;
		logic [7:0]      thousands_segments;
		logic [7:0]      hundreds_segments;
		logic [7:0]      tens_segments;
		logic [7:0]      ones_segments;
	} disp_res_t;

	// Tracks the button state and the limits, and holds the display requests
	// that are still due from the block.
	class display_scoreboard;
		stbc_cfg_t       cfg;
		logic [PosW-1:0] position;
		logic            pulse_mode;
		int unsigned     hold_ticks;
		logic            hold_locked;
		logic            middle_prev;
		disp_res_t       pending_displays [$];
		int              mismatches;

		function new();
			cfg = '{LongPressReset, AngleMinReset, AngleMidReset, AngleMaxReset,
				PulseMinReset, PulseMidReset, PulseMaxReset, PulseStepReset};
			position = AngleMidReset;
			pulse_mode = 1'b0;
			hold_ticks = 0;
			hold_locked = 1'b0;
			middle_prev = 1'b0;
			mismatches = 0;
		endfunction

		// Only the low bits of the data word that fit the register are kept.
		function void write_reg(input stbc_reg_idx_t idx, input logic [DataW-1:0] word);
			case (idx)
				REG_LONG_PRESS: cfg.long_press_ticks = word[CntW-1:0];
				REG_ANGLE_MIN:  cfg.angle_min = word[PosW-1:0];
				REG_ANGLE_MID:  cfg.angle_mid = word[PosW-1:0];
				REG_ANGLE_MAX:  cfg.angle_max = word[PosW-1:0];
				REG_PULSE_MIN:  cfg.pulse_min = word[PosW-1:0];
				REG_PULSE_MID:  cfg.pulse_mid = word[PosW-1:0];
				REG_PULSE_MAX:  cfg.pulse_max = word[PosW-1:0];
				REG_PULSE_STEP: cfg.pulse_step = word[StepW-1:0];
				default: ;
			endcase
		endfunction

		function void mode_range(output int unsigned lo, output int unsigned md,
			output int unsigned hi);
			if (pulse_mode) begin
				lo = cfg.pulse_min;
				md = cfg.pulse_mid;
				hi = cfg.pulse_max;
			end else begin
				lo = cfg.angle_min;
				md = cfg.angle_mid;
				hi = cfg.angle_max;
			end
		endfunction

		// Applies one tick of button levels and queues the display it causes.
		function void predict_display(input logic lft, input logic mid, input logic rgt);
			int unsigned lo, md, hi, step, pos, nxt, v, d;
			logic beep;
			disp_res_t e;
			beep = 1'b0;
			mode_range(lo, md, hi);
			// In angle mode a unit step makes the bound checks plain compares.
			step = pulse_mode ? int'(cfg.pulse_step) : 1;
			pos = position;
			if (lft && pos >= lo + step) begin
				pos = pos - step;
			end
			if (rgt && pos + step <= hi) begin
				pos = pos + step;
			end

			// A hold past the long-press count flips the mode once per press.
			if (!hold_locked && mid) begin
				nxt = hold_ticks + 1;
				if (nxt > cfg.long_press_ticks) begin
					pulse_mode = ~pulse_mode;
					mode_range(lo, md, hi);
					pos = md;
					hold_locked = 1'b1;
					beep = 1'b1;
				end
				hold_ticks = (nxt > 255) ? 255 : nxt;
			end

			// A release that did not switch the mode walks middle, max, min.
			if (!mid && middle_prev) begin
				hold_ticks = 0;
				if (hold_locked) begin
					hold_locked = 1'b0;
				end else if (pos != lo && pos != md && pos != hi) begin
					pos = md;
				end else if (pos == lo) begin
					pos = md;
				end else if (pos == md) begin
					pos = hi;
				end else begin
					pos = lo;
				end
			end
			middle_prev = mid;
			position = pos[PosW-1:0];

			v = position;
			d = v / 1000;
			e.thousands_segments = {~pulse_mode, (d < 10) ? Glyph[d] : 7'h00};
			v = v - d * 1000;
			e.hundreds_segments = {1'b0, Glyph[(v / 100) % 10]};
			v = v % 100;
			e.tens_segments = {1'b0, Glyph[(v / 10) % 10]};
			e.ones_segments = {pulse_mode, Glyph[v % 10]};
			e.position = position;
			e.pulse_mode = pulse_mode;
			e.beep = beep;
			pending_displays.push_back(e);
		endfunction

		function void report(input string what, input disp_res_t e, input disp_res_t got);
			mismatches++;
			if (mismatches <= MaxReports) begin
				$display("%s: expected pos %0d mode %0b beep %0b seg %h %h %h %h,",
					what, e.position, e.pulse_mode, e.beep, e.thousands_segments,
					e.hundreds_segments, e.tens_segments, e.ones_segments);
				$display("    got pos %0d mode %0b beep %0b seg %h %h %h %h",
					got.position, got.pulse_mode, got.beep, got.thousands_segments,
					got.hundreds_segments, got.tens_segments, got.ones_segments);
			end
		endfunction

		function void check_display(input disp_res_t got);
			disp_res_t e;
			if (pending_displays.size() == 0) begin
				report("unexpected display request", '0, got);
				return;
			end
			e = pending_displays.pop_front();
			if (got.position !== e.position || got.pulse_mode !== e.pulse_mode ||
				got.beep !== e.beep || got.thousands_segments !== e.thousands_segments ||
				got.hundreds_segments !== e.hundreds_segments ||
				got.tens_segments !== e.tens_segments ||
				got.ones_segments !== e.ones_segments) begin
				report("display mismatch", e, got);
			end
		endfunction

		function void flush_missing();
			while (pending_displays.size() != 0) begin
				report("missing display request", pending_displays.pop_front(), '0);
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;

	stbc_in_if  btn_if ();
	stbc_out_if disp_if ();

	display_scoreboard board = new();
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cur_long_press = LongPressReset;

	servo_tester_button_control u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.btn     (btn_if),
		.disp    (disp_if)
	);

	always #5 clk = ~clk;

	// Sends one tick request, with random gaps in front of it.
	task automatic send_tick(input logic lft, input logic mid, input logic rgt);
		while ($urandom_range(99) < send_idle_pct) begin
			btn_if.valid <= 1'b0;
			@(posedge clk);
		end
		btn_if.valid <= 1'b1;
		btn_if.left_pressed <= lft;
		btn_if.middle_pressed <= mid;
		btn_if.right_pressed <= rgt;
		do @(posedge clk); while (!btn_if.ready);
	endtask

	// APB write: setup, access, then idle before the next transfer;
	// the bits above the register may hold junk.
	task automatic write_register(input stbc_reg_idx_t idx, input int value);
		logic [DataW-1:0] word;
		word = $urandom_range(1) ? DataW'($urandom) : '0;
		if (idx == REG_LONG_PRESS || idx == REG_PULSE_STEP) begin
			word[CntW-1:0] = value[CntW-1:0];
		end else begin
			word[PosW-1:0] = value[PosW-1:0];
		end
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.write_reg(idx, word);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input int lp, input int amin, input int amid, input int amax,
		input int pmin, input int pmid, input int pmax, input int stp);
		write_register(REG_LONG_PRESS, lp);
		write_register(REG_ANGLE_MIN, amin);
		write_register(REG_ANGLE_MID, amid);
		write_register(REG_ANGLE_MAX, amax);
		write_register(REG_PULSE_MIN, pmin);
		write_register(REG_PULSE_MID, pmid);
		write_register(REG_PULSE_MAX, pmax);
		write_register(REG_PULSE_STEP, stp);
		cur_long_press = lp;
	endtask

	// Holds the sender back until every display request has come back.
	task automatic wait_for_displays();
		btn_if.valid <= 1'b0;
		do @(posedge clk); while (board.pending_displays.size() != 0);
	endtask

	// Random button gestures: step runs, short and long middle presses, noise.
	task automatic press_sequence(input int n_ticks);
		int sent, len, kind, k;
		logic lft, rgt;
		sent = 0;
		while (sent < n_ticks) begin
			kind = $urandom_range(99);
			if (kind < 35) begin
				len = $urandom_range(12, 1);
				lft = 1'($urandom);
				rgt = 1'($urandom);
				for (k = 0; k < len; k++) send_tick(lft, 1'b0, rgt);
			end else if (kind < 80) begin
				// Short presses stay at or below the count unless it is zero, long ones pass it.
				if (kind < 60) begin
					len = $urandom_range((cur_long_press > 1) ? cur_long_press : 1, 1);
				end else begin
					len = cur_long_press + 1 + $urandom_range(4);
				end
				for (k = 0; k < len; k++) send_tick(1'($urandom), 1'b1, 1'($urandom));
				send_tick(1'($urandom), 1'b0, 1'($urandom));
				len = len + 1;
			end else begin
				len = $urandom_range(6, 1);
				for (k = 0; k < len; k++) send_tick(1'($urandom), 1'($urandom), 1'($urandom));
			end
			sent = sent + len;
		end
	endtask

	// Limit settings of the later phases, with the extremes among them.
	task automatic apply_setting(input int phase);
		int lo, md, hi;
		case (phase)
			1: set_limits(3, 0, 90, 180, 500, 1500, 2500, 7);
			// Blank thousands digit, full-width limits and the longest hold.
			2: set_limits(255, 0, 9999, 16383, 0, 16383, 16383, 255);
			// Coinciding limits and a zero pulse step.
			3: set_limits(1, 50, 50, 50, 100, 100, 200, 0);
			// Zero count flips on the first held tick; middle above max.
			4: set_limits(0, 10, 20, 15, 9990, 9995, 9999, 1);
			5: begin
				lo = $urandom_range(3000);
				md = lo + $urandom_range(3000);
				hi = md + $urandom_range(3999);
				set_limits(6, lo, md, hi, hi - md, hi - lo, hi, $urandom_range(255, 1));
			end
			6: set_limits($urandom_range(10, 1), $urandom_range(9999), $urandom_range(9999),
				$urandom_range(9999), $urandom_range(9999), $urandom_range(9999),
				$urandom_range(9999), $urandom_range(255));
			default: set_limits(LongPressReset, AngleMinReset, AngleMidReset, AngleMaxReset,
				PulseMinReset, PulseMidReset, PulseMaxReset, PulseStepReset);
		endcase
	endtask

	// Main stimulus: reset, directed ticks, then one random phase per setting.
	initial begin
		int k, phase;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		btn_if.valid = 1'b0;
		btn_if.left_pressed = 1'b0;
		btn_if.middle_pressed = 1'b0;
		btn_if.right_pressed = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every button combination, then middle taps that walk the positions.
		for (k = 0; k < 8; k++) send_tick(k[0], k[1], k[2]);
		for (k = 0; k < 4; k++) begin
			send_tick(1'b0, 1'b1, 1'b0);
			send_tick(1'b0, 1'b0, 1'b0);
		end
		press_sequence(140);

		for (phase = 1; phase < 8; phase++) begin
			wait_for_displays();
			apply_setting(phase);
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 62; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 62; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			press_sequence((phase == 2) ? 420 : 120);
		end

		wait_for_displays();
		repeat (12) @(posedge clk);
		board.flush_missing();
		if (board.mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Notes accepted ticks, checks display requests and drives the receiver.
	initial begin
		disp_res_t got;
		disp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && btn_if.valid && btn_if.ready) begin
				board.predict_display(btn_if.left_pressed, btn_if.middle_pressed,
					btn_if.right_pressed);
			end
			if (arst_n && disp_if.valid && disp_if.ready) begin
				got.position = disp_if.position;
				got.pulse_mode = disp_if.pulse_mode;
				got.beep = disp_if.beep;
				got.thousands_segments = disp_if.thousands_segments;
				got.hundreds_segments = disp_if.hundreds_segments;
				got.tens_segments = disp_if.tens_segments;
				got.ones_segments = disp_if.ones_segments;
				board.check_display(got);
			end
			if ((btn_if.valid && btn_if.ready) || (disp_if.valid && disp_if.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			disp_if.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Ends a run in which no request has moved for too long.
	initial begin
		while (idle_cycles < StallLimit) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

endmodule
